FILE: rtl/core/apid_pkg.sv
// Package for the anti-windup PID controller: types, widths, register indexes,
// datapath command codes. No dependencies.
package apid_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int CFG_COUNT = 8;
    localparam int CFG_IDX_W = 3;
    localparam int GAIN_SHIFT = 24;

    localparam logic [CFG_IDX_W-1:0] REG_KP   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BETA = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BI   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BR   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_AD   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BD   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_VA   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_VB   = 3'd7;

    localparam logic [31:0] GAIN_ONE = 32'h0100_0000;

    // datapath operation codes
    localparam logic [3:0] OP_NONE   = 4'd0;
    localparam logic [3:0] OP_LOAD   = 4'd1;  // latch the request
    localparam logic [3:0] OP_BR     = 4'd2;  // t0 = beta*r
    localparam logic [3:0] OP_P      = 4'd3;  // p = kp*(t0 - y)
    localparam logic [3:0] OP_DIVGO  = 4'd4;  // start preset division
    localparam logic [3:0] OP_PRESET = 4'd5;  // I = q - p, D = 0, yprev = y
    localparam logic [3:0] OP_D1     = 4'd6;  // t0 = D*ad
    localparam logic [3:0] OP_D2     = 4'd7;  // D = t0 - bd*(y - yprev)
    localparam logic [3:0] OP_V      = 4'd8;  // v = va + vb*(p+I+D), clamp
    localparam logic [3:0] OP_I1     = 4'd9;  // t0 = bi*(r - y)
    localparam logic [3:0] OP_I2     = 4'd10; // I = I + t0 + br*(u - v)

    typedef struct packed {
        logic [3:0] op;
    } apid_cmd_t;

    typedef struct packed {
        logic div_busy;
    } apid_stat_t;

endpackage

FILE: rtl/core/apid_div.sv
// Restoring divider for the bumpless preset: (n << 24) / d, truncated, saturated.
// Depends on apid_pkg.
module apid_div #(
    parameter int DW = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [DW-1:0] num,
    input  logic signed [DW-1:0] den,
    output logic                 busy,
    output logic signed [DW-1:0] quot
);
    localparam int NW = DW + apid_pkg::GAIN_SHIFT;
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0]  q_reg, q_next;
    logic [DW:0]    r_reg, r_next;
    logic [DW-1:0]  d_reg, d_next;
    logic           neg_reg, neg_next;
    logic           z_reg, z_next;
    logic [1:0]     zs_reg, zs_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic           busy_reg, busy_next;
    logic [DW-1:0]  nmag;
    logic [DW:0]    trial;
    logic [NW:0]    qmag;
    logic signed [NW+1:0] qs;
    logic signed [NW+1:0] smax, smin;

    always_comb
    begin
        nmag = num[DW-1] ? DW'(-num) : DW'(num);
        q_next = q_reg;
        r_next = r_reg;
        d_next = d_reg;
        neg_next = neg_reg;
        z_next = z_reg;
        zs_next = zs_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        trial = {r_reg[DW-1:0], q_reg[NW-1]} - {1'b0, d_reg};
        if (start)
        begin
            q_next = {nmag, {apid_pkg::GAIN_SHIFT{1'b0}}};
            r_next = '0;
            d_next = den[DW-1] ? DW'(-den) : DW'(den);
            neg_next = num[DW-1] ^ den[DW-1];
            z_next = (den == '0);
            zs_next = {num[DW-1], num != '0};
            cnt_next = CW'(NW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[DW])
            begin
                r_next = trial;
                q_next = {q_reg[NW-2:0], 1'b1};
            end
            else
            begin
                r_next = {r_reg[DW-1:0], q_reg[NW-1]};
                q_next = {q_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
        neg_reg <= neg_next;
        z_reg <= z_next;
        zs_reg <= zs_next;
    end

    always_comb
    begin
        smax = (NW+2)'({1'b0, {(DW-1){1'b1}}});
        smin = -smax - (NW+2)'(1);
        qmag = {1'b0, q_reg};
        qs = neg_reg ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
        if (z_reg)
        begin
            if (!zs_reg[0])
                quot = '0;
            else if (zs_reg[1])
                quot = DW'(smin);
            else
                quot = DW'(smax);
        end
        else if (qs > smax)
            quot = DW'(smax);
        else if (qs < smin)
            quot = DW'(smin);
        else
            quot = DW'(qs);
    end

    assign busy = busy_reg;
endmodule

FILE: rtl/core/apid_datapath.sv
// Datapath: shared gain multiplier, saturating adders, state registers, divider.
// Depends on apid_pkg and apid_div.
module apid_datapath #(
    parameter int DW = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  apid_pkg::apid_cmd_t    cmd,
    output apid_pkg::apid_stat_t   stat,
    input  logic                   cfg_we,
    input  logic [apid_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  logic [31:0]            cfg_data,
    input  logic [31:0]            setpoint,
    input  logic [31:0]            measured,
    input  logic [31:0]            out_low,
    input  logic [31:0]            out_high,
    input  logic [31:0]            restart_output,
    output logic [31:0]            actuator_out,
    output logic                   clamped_low,
    output logic                   clamped_high
);
    localparam int EW = DW + 2;
    localparam int PW = DW + 32;

    logic signed [31:0] kp_reg, beta_reg, bi_reg, br_reg, ad_reg, bd_reg, va_reg, vb_reg;
    logic signed [DW-1:0] r_reg, y_reg, lo_reg, hi_reg, u0_reg;
    logic signed [DW-1:0] p_reg, t0_reg, i_reg, d_reg, yp_reg, v_reg, u_reg;
    logic cl_reg, ch_reg;

    logic signed [DW-1:0] ma, mres, diff, q, qd;
    logic signed [31:0]   mg;
    logic signed [PW-1:0] prod;

    function automatic logic signed [DW-1:0] satw(input logic signed [EW-1:0] x);
        logic signed [EW-1:0] mx;
        logic signed [EW-1:0] mn;
        begin
            mx = EW'({1'b0, {(DW-1){1'b1}}});
            mn = -mx - EW'(1);
            if (x > mx)
                satw = DW'(mx);
            else if (x < mn)
                satw = DW'(mn);
            else
                satw = DW'(x);
        end
    endfunction

    function automatic logic signed [DW-1:0] satp(input logic signed [PW-1:0] x);
        logic signed [PW-1:0] mx;
        logic signed [PW-1:0] mn;
        begin
            mx = PW'({1'b0, {(DW-1){1'b1}}});
            mn = -mx - PW'(1);
            if (x > mx)
                satp = DW'(mx);
            else if (x < mn)
                satp = DW'(mn);
            else
                satp = DW'(x);
        end
    endfunction

    function automatic logic signed [DW-1:0] sadd(input logic signed [DW-1:0] a,
                                                  input logic signed [DW-1:0] b);
        sadd = satw(EW'(a) + EW'(b));
    endfunction

    function automatic logic signed [DW-1:0] ssub(input logic signed [DW-1:0] a,
                                                  input logic signed [DW-1:0] b);
        ssub = satw(EW'(a) - EW'(b));
    endfunction

    function automatic logic signed [DW-1:0] sadd3(input logic signed [DW-1:0] a,
                                                   input logic signed [DW-1:0] b,
                                                   input logic signed [DW-1:0] c);
        sadd3 = satw(EW'(a) + EW'(b) + EW'(c));
    endfunction

    // multiplier operand selection
    always_comb
    begin
        ma = '0;
        mg = '0;
        diff = ssub(u_reg, v_reg);
        unique case (cmd.op)
            apid_pkg::OP_BR:
            begin
                ma = r_reg;
                mg = beta_reg;
            end
            apid_pkg::OP_P:
            begin
                ma = ssub(t0_reg, y_reg);
                mg = kp_reg;
            end
            apid_pkg::OP_D1:
            begin
                ma = d_reg;
                mg = ad_reg;
            end
            apid_pkg::OP_D2:
            begin
                ma = ssub(y_reg, yp_reg);
                mg = bd_reg;
            end
            apid_pkg::OP_V:
            begin
                ma = sadd3(p_reg, i_reg, d_reg);
                mg = vb_reg;
            end
            apid_pkg::OP_I1:
            begin
                ma = ssub(r_reg, y_reg);
                mg = bi_reg;
            end
            apid_pkg::OP_I2:
            begin
                ma = diff;
                mg = br_reg;
            end
            default:
            begin
                ma = '0;
                mg = '0;
            end
        endcase
        prod = PW'(ma) * PW'(mg);
        mres = satp(prod >>> apid_pkg::GAIN_SHIFT);
    end

    logic div_start, div_busy;
    assign div_start = (cmd.op == apid_pkg::OP_DIVGO);

    apid_div #(.DW(DW)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (ssub(u0_reg, DW'(va_reg))),
        .den   (DW'(vb_reg)),
        .busy  (div_busy),
        .quot  (q)
    );
    assign qd = q;
    assign stat.div_busy = div_busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg <= '0;
            beta_reg <= apid_pkg::GAIN_ONE;
            bi_reg <= '0;
            br_reg <= '0;
            ad_reg <= '0;
            bd_reg <= '0;
            va_reg <= '0;
            vb_reg <= apid_pkg::GAIN_ONE;
            i_reg <= '0;
            d_reg <= '0;
            yp_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_idx)
                    apid_pkg::REG_KP:   kp_reg <= cfg_data;
                    apid_pkg::REG_BETA: beta_reg <= cfg_data;
                    apid_pkg::REG_BI:   bi_reg <= cfg_data;
                    apid_pkg::REG_BR:   br_reg <= cfg_data;
                    apid_pkg::REG_AD:   ad_reg <= cfg_data;
                    apid_pkg::REG_BD:   bd_reg <= cfg_data;
                    apid_pkg::REG_VA:   va_reg <= cfg_data;
                    apid_pkg::REG_VB:   vb_reg <= cfg_data;
                    default:            kp_reg <= kp_reg;
                endcase
            end
            unique case (cmd.op)
                apid_pkg::OP_PRESET:
                begin
                    i_reg <= ssub(qd, p_reg);
                    d_reg <= '0;
                    yp_reg <= y_reg;
                end
                apid_pkg::OP_D2:
                begin
                    d_reg <= ssub(t0_reg, mres);
                    yp_reg <= y_reg;
                end
                apid_pkg::OP_I2:
                begin
                    i_reg <= sadd3(i_reg, t0_reg, mres);
                end
                default:
                begin
                    i_reg <= i_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            apid_pkg::OP_LOAD:
            begin
                r_reg <= DW'(signed'(setpoint));
                y_reg <= DW'(signed'(measured));
                lo_reg <= DW'(signed'(out_low));
                hi_reg <= DW'(signed'(out_high));
                u0_reg <= DW'(signed'(restart_output));
            end
            apid_pkg::OP_BR, apid_pkg::OP_D1, apid_pkg::OP_I1:
            begin
                t0_reg <= mres;
            end
            apid_pkg::OP_P:
            begin
                p_reg <= mres;
            end
            apid_pkg::OP_V:
            begin
                v_reg <= sadd(DW'(va_reg), mres);
                if (sadd(DW'(va_reg), mres) < lo_reg)
                begin
                    u_reg <= lo_reg;
                    cl_reg <= 1'b1;
                    ch_reg <= 1'b0;
                end
                else if (sadd(DW'(va_reg), mres) > hi_reg)
                begin
                    u_reg <= hi_reg;
                    cl_reg <= 1'b0;
                    ch_reg <= 1'b1;
                end
                else
                begin
                    u_reg <= sadd(DW'(va_reg), mres);
                    cl_reg <= 1'b0;
                    ch_reg <= 1'b0;
                end
            end
            default:
            begin
                t0_reg <= t0_reg;
            end
        endcase
    end

    assign actuator_out = u_reg[31:0];
    assign clamped_low = cl_reg;
    assign clamped_high = ch_reg;
endmodule

FILE: rtl/core/apid_ctrl.sv
// Sequencer for one controller step: handshakes and datapath command issue.
// Depends on apid_pkg.
module apid_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 restart,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  logic                 cfg_write,
    input  apid_pkg::apid_stat_t stat,
    output apid_pkg::apid_cmd_t  cmd
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_BR    = 4'd1;
    localparam logic [3:0] S_P     = 4'd2;
    localparam logic [3:0] S_DIVGO = 4'd3;
    localparam logic [3:0] S_DIVW  = 4'd4;
    localparam logic [3:0] S_PRE   = 4'd5;
    localparam logic [3:0] S_D1    = 4'd6;
    localparam logic [3:0] S_D2    = 4'd7;
    localparam logic [3:0] S_V     = 4'd8;
    localparam logic [3:0] S_I1    = 4'd9;
    localparam logic [3:0] S_I2    = 4'd10;
    localparam logic [3:0] S_OUT   = 4'd11;

    logic [3:0] state_reg, state_next;
    logic       init_reg, init_next;
    logic       rst_req_reg, rst_req_next;
    logic       dwait_reg, dwait_next;

    always_comb
    begin
        state_next = state_reg;
        init_next = init_reg | cfg_write;
        rst_req_next = rst_req_reg;
        dwait_next = 1'b0;
        cmd.op = apid_pkg::OP_NONE;
        in_ready = (state_reg == S_IDLE);
        out_valid = (state_reg == S_OUT);
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op = apid_pkg::OP_LOAD;
                    rst_req_next = restart;
                    state_next = S_BR;
                end
            end
            S_BR:
            begin
                cmd.op = apid_pkg::OP_BR;
                state_next = S_P;
            end
            S_P:
            begin
                cmd.op = apid_pkg::OP_P;
                state_next = (init_reg || rst_req_reg) ? S_DIVGO : S_D1;
            end
            S_DIVGO:
            begin
                cmd.op = apid_pkg::OP_DIVGO;
                dwait_next = 1'b1;
                state_next = S_DIVW;
            end
            S_DIVW:
            begin
                if (!dwait_reg && !stat.div_busy)
                    state_next = S_PRE;
            end
            S_PRE:
            begin
                cmd.op = apid_pkg::OP_PRESET;
                init_next = 1'b0;
                state_next = S_D1;
            end
            S_D1:
            begin
                cmd.op = apid_pkg::OP_D1;
                state_next = S_D2;
            end
            S_D2:
            begin
                cmd.op = apid_pkg::OP_D2;
                state_next = S_V;
            end
            S_V:
            begin
                cmd.op = apid_pkg::OP_V;
                state_next = S_I1;
            end
            S_I1:
            begin
                cmd.op = apid_pkg::OP_I1;
                state_next = S_I2;
            end
            S_I2:
            begin
                cmd.op = apid_pkg::OP_I2;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            init_reg <= 1'b1;
            rst_req_reg <= 1'b0;
            dwait_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            init_reg <= init_next;
            rst_req_reg <= rst_req_next;
            dwait_reg <= dwait_next;
        end
    end
endmodule

FILE: rtl/core/antiwindup_pid_controller_top.sv
// PID controller with back-calculation anti-windup, Q16.16 signals, Q8.24 gains.
// Steps per request: LOAD, BR, P, D1, D2, V, I1, I2; a preset adds divider start,
// wait and PRESET (one bit per cycle in the preset divider, DATA_WIDTH+24 steps).
// Throughput: one request at a time; the next is taken after the result leaves.
// Reset: registers to defaults, integral/derivative zero, preset pending.
// Depends on apid_pkg, apid_ctrl, apid_datapath.
module antiwindup_pid_controller_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] setpoint,
    input  logic [31:0] measured,
    input  logic [31:0] out_low,
    input  logic [31:0] out_high,
    input  logic        restart,
    input  logic [31:0] restart_output,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] actuator_out,
    output logic        clamped_low,
    output logic        clamped_high,
    input  logic        cfg_we,
    input  logic [3:0]  cfg_addr,
    input  logic [31:0] cfg_wdata
);
    apid_pkg::apid_cmd_t  cmd;
    apid_pkg::apid_stat_t stat;
    logic cfg_ok;

    assign cfg_ok = cfg_we && (cfg_addr < 4'(apid_pkg::CFG_COUNT));

    apid_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .restart   (restart),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cfg_write (cfg_ok),
        .stat      (stat),
        .cmd       (cmd)
    );

    apid_datapath #(.DW(apid_pkg::DATA_WIDTH)) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .cfg_we         (cfg_ok),
        .cfg_idx        (cfg_addr[apid_pkg::CFG_IDX_W-1:0]),
        .cfg_data       (cfg_wdata),
        .setpoint       (setpoint),
        .measured       (measured),
        .out_low        (out_low),
        .out_high       (out_high),
        .restart_output (restart_output),
        .actuator_out   (actuator_out),
        .clamped_low    (clamped_low),
        .clamped_high   (clamped_high)
    );
endmodule
